FILE: design/nsse_pkg.sv
// Package: shared types, constants and helpers for the nine-slice sprite expander.
`default_nettype none
package nsse_pkg;

    localparam int TILE_REPEAT_MAX = 4;
    localparam int HALF_PIXEL_Q4   = 8;
    localparam int ROUND_Q4        = 128;

    localparam int POS_W  = 26;   // internal positions
    localparam int SCL_W  = 24;   // scaled lengths, Q.4
    localparam int MUL_A_W = 26;
    localparam int MUL_B_W = 18;
    localparam int PROD_W = MUL_A_W + MUL_B_W;
    localparam int DEN_W  = 25;
    localparam int Q_W    = PROD_W + 1;
    localparam int SUM_W  = Q_W + 1;
    localparam int CNT_W  = $clog2(PROD_W);
    localparam int REP_W  = $clog2(TILE_REPEAT_MAX + 1);

    typedef struct packed {
        logic signed [15:0] dest_x;
        logic signed [15:0] dest_y;
        logic signed [15:0] dest_w;
        logic signed [15:0] dest_h;
        logic [15:0]        inset_scale;
        logic [63:0]        uv_rect;
        logic [31:0]        source_size;
        logic [63:0]        slice_insets;
        logic [3:0]         mode_flags;
        logic [31:0]        tint_color;
    } cmd_t;

    typedef struct packed {
        logic signed [15:0] quad_x;
        logic signed [15:0] quad_y;
        logic signed [15:0] quad_w;
        logic signed [15:0] quad_h;
        logic [15:0]        tex_u0;
        logic [15:0]        tex_v0;
        logic [15:0]        tex_u1;
        logic [15:0]        tex_v1;
        logic [15:0]        texture_slot;
        logic [31:0]        quad_color;
        logic               last_quad;
    } quad_t;

    function automatic logic [15:0] sat_s16(input logic signed [POS_W-1:0] v);
        if (v > POS_W'(32767))
            return 16'h7fff;
        else if (v < -POS_W'(32768))
            return 16'h8000;
        else
            return v[15:0];
    endfunction

    function automatic logic [15:0] clamp_u16(input logic signed [SUM_W-1:0] v);
        if (v < 0)
            return 16'h0000;
        else if (v > SUM_W'(65535))
            return 16'hffff;
        else
            return v[15:0];
    endfunction

endpackage
`default_nettype wire

FILE: design/nine_slice_sprite_expander_unit.sv
// Nine-slice sprite expander: sequencer around one shared multiplier and one serial divider.
`default_nettype none
// A command is taken when start is high and busy is low; busy drops as the last
// quad of that command is strobed out. Quads appear on quad for one cycle each,
// marked by quad_valid, and cannot be held off, so the receiver must take every one.
// last_quad flags the final quad of a command; a command that yields nothing produces no
// strobe at all. How long a command takes depends on its divisions, each run on a restoring
// divider at one quotient bit per cycle; a nine-slice command needs six lengths scaled (four
// insets and two tile pitches), up to two inset shrinks, four track UVs, and per tiled piece
// one repeat count per axis plus one lerp for each trimmed row and for each trimmed column
// in every row. Emission passes ST_ROW for each row, and ST_COL and ST_EMIT for each quad.
// The atlas slot register is written through cfg_valid/cfg_ready while busy is low.
module nine_slice_sprite_expander_unit (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire nsse_pkg::cmd_t  cmd,
    input  wire logic            cfg_valid,
    output logic                 cfg_ready,
    input  wire logic [15:0]     cfg_data,
    output logic                 quad_valid,
    output nsse_pkg::quad_t      quad
);
    import nsse_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE, ST_SCL_MUL, ST_SCL_WB, ST_DECIDE, ST_SHR_CHK, ST_SHR_MUL, ST_SHR_WB,
        ST_FLIP, ST_TRK_MUL, ST_TRK_WB, ST_DIV_GO, ST_DIV_WAIT, ST_PC_START,
        ST_REP_X, ST_REP_XWB, ST_REP_Y, ST_REP_YWB, ST_ROW, ST_ROW_MUL, ST_ROW_WB,
        ST_COL, ST_COL_MUL, ST_COL_WB, ST_EMIT, ST_NEXT, ST_FLUSH
    } state_t;

    state_t state_reg, div_ret_reg;

    logic [15:0] slot_reg;
    cmd_t        cmd_reg;

    // scaled lengths: L, R, T, B, pitch x, pitch y
    logic [SCL_W-1:0] scl_reg [0:5];
    // inner track UVs: su1, su2, sv1, sv2
    logic [15:0]      trk_reg [0:3];
    logic [2:0]       idx_reg;
    logic [1:0]       gi_reg, gj_reg;

    // current piece
    logic signed [POS_W-1:0] pcx_reg, pcy_reg, pcw_reg, pch_reg;
    logic [SCL_W-1:0]        ptx_reg, pty_reg;
    logic [REP_W-1:0]        nx_reg, ny_reg, ci_reg, rj_reg;
    logic [15:0]             pu0_reg, pu1_reg, pv0_reg, pv1_reg;
    // current row / column
    logic signed [POS_W-1:0] py_reg, ph_reg, px_reg, pw_reg;
    logic [15:0]             pv1q_reg, pu1q_reg;

    logic              pend_valid_reg;
    quad_t             pend_reg;
    quad_t             quad_reg;
    logic              quad_valid_reg;

    // shared multiplier
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod_reg;

    // serial divider
    logic                     div_start_reg;
    logic signed [PROD_W-1:0] div_num_reg;
    logic [DEN_W-1:0]         div_den_reg;
    logic                     div_run_reg, div_done_reg, div_neg_reg;
    logic [PROD_W-1:0]        div_mag_reg;
    logic [DEN_W:0]           div_rem_reg;
    logic [CNT_W-1:0]         div_cnt_reg;
    logic signed [Q_W-1:0]    div_q;

    // command fields
    logic signed [POS_W-1:0] x, y, w, h;
    logic [15:0] s, u0, v0, u1, v1, sw, sh, il, ir, it, ib;
    logic flipx, flipy, tile, nine;

    assign x     = POS_W'(cmd_reg.dest_x);
    assign y     = POS_W'(cmd_reg.dest_y);
    assign w     = POS_W'(cmd_reg.dest_w);
    assign h     = POS_W'(cmd_reg.dest_h);
    assign s     = cmd_reg.inset_scale;
    assign u0    = cmd_reg.uv_rect[15:0];
    assign v0    = cmd_reg.uv_rect[31:16];
    assign u1    = cmd_reg.uv_rect[47:32];
    assign v1    = cmd_reg.uv_rect[63:48];
    assign sw    = cmd_reg.source_size[15:0];
    assign sh    = cmd_reg.source_size[31:16];
    assign il    = cmd_reg.slice_insets[15:0];
    assign ir    = cmd_reg.slice_insets[31:16];
    assign it    = cmd_reg.slice_insets[47:32];
    assign ib    = cmd_reg.slice_insets[63:48];
    assign flipx = cmd_reg.mode_flags[0];
    assign flipy = cmd_reg.mode_flags[1];
    assign tile  = cmd_reg.mode_flags[2];
    assign nine  = cmd_reg.mode_flags[3];

    // derived terms
    logic signed [17:0]      cx_mid, cy_mid;
    logic [15:0]             scl_n;
    logic [DEN_W-1:0]        shr_sum;
    logic signed [POS_W-1:0] shr_ext;
    logic signed [POS_W-1:0] dxa, dxb, dya, dyb;
    logic [15:0]             su [0:3];
    logic [15:0]             sv [0:3];
    logic signed [POS_W-1:0] row_ph, col_pw;
    logic signed [POS_W-1:0] ptx_s, pty_s;
    logic signed [SUM_W-1:0] trk_sum, lerp_v, lerp_u;

    function automatic logic signed [POS_W-1:0] grid_x(input logic [1:0] k,
        input logic signed [POS_W-1:0] o, input logic signed [POS_W-1:0] e,
        input logic [SCL_W-1:0] a, input logic [SCL_W-1:0] b);
        case (k)
            2'd0:    return o;
            2'd1:    return o + POS_W'(a);
            2'd2:    return o + e - POS_W'(b);
            default: return o + e;
        endcase
    endfunction

    always_comb
    begin
        cx_mid = 18'(signed'({2'b0, sw})) - 18'(il) - 18'(ir);
        cy_mid = 18'(signed'({2'b0, sh})) - 18'(it) - 18'(ib);
        case (idx_reg)
            3'd0:    scl_n = il;
            3'd1:    scl_n = ir;
            3'd2:    scl_n = it;
            3'd3:    scl_n = ib;
            3'd4:    scl_n = (tile && cx_mid > 0) ? cx_mid[15:0] : 16'd0;
            default: scl_n = (tile && cy_mid > 0) ? cy_mid[15:0] : 16'd0;
        endcase

        if (idx_reg[0])
        begin
            shr_sum = DEN_W'(scl_reg[2]) + DEN_W'(scl_reg[3]);
            shr_ext = h;
        end
        else
        begin
            shr_sum = DEN_W'(scl_reg[0]) + DEN_W'(scl_reg[1]);
            shr_ext = w;
        end

        dxa = grid_x(gi_reg, x, w, scl_reg[0], scl_reg[1]);
        dxb = grid_x(gi_reg + 2'd1, x, w, scl_reg[0], scl_reg[1]);
        dya = grid_x(gj_reg, y, h, scl_reg[2], scl_reg[3]);
        dyb = grid_x(gj_reg + 2'd1, y, h, scl_reg[2], scl_reg[3]);

        su[0] = u0; su[1] = trk_reg[0]; su[2] = trk_reg[1]; su[3] = u1;
        sv[0] = v0; sv[1] = trk_reg[2]; sv[2] = trk_reg[3]; sv[3] = v1;

        ptx_s = POS_W'(ptx_reg);
        pty_s = POS_W'(pty_reg);

        // trim the trailing repeat to the piece's far edge
        row_ph = (pty_reg != '0) ? pty_s : pch_reg;
        if (py_reg + row_ph > pcy_reg + pch_reg)
            row_ph = pcy_reg + pch_reg - py_reg;
        col_pw = (ptx_reg != '0) ? ptx_s : pcw_reg;
        if (px_reg + col_pw > pcx_reg + pcw_reg)
            col_pw = pcx_reg + pcw_reg - px_reg;

        case (idx_reg[1:0])
            2'd0:    trk_sum = SUM_W'(signed'({1'b0, u0})) + SUM_W'(div_q);
            2'd1:    trk_sum = SUM_W'(signed'({1'b0, u1})) - SUM_W'(div_q);
            2'd2:    trk_sum = SUM_W'(signed'({1'b0, v0})) + SUM_W'(div_q);
            default: trk_sum = SUM_W'(signed'({1'b0, v1})) - SUM_W'(div_q);
        endcase
        lerp_v = SUM_W'(signed'({1'b0, pv0_reg})) + SUM_W'(div_q);
        lerp_u = SUM_W'(signed'({1'b0, pu0_reg})) + SUM_W'(div_q);

        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_SCL_MUL:
            begin
                mul_a = MUL_A_W'(scl_n);
                mul_b = MUL_B_W'(s);
            end
            ST_SHR_MUL:
            begin
                mul_a = MUL_A_W'(idx_reg[0] ? scl_reg[2] : scl_reg[0]);
                mul_b = MUL_B_W'(shr_ext);
            end
            ST_TRK_MUL:
            begin
                case (idx_reg[1:0])
                    2'd0:    mul_a = MUL_A_W'(il);
                    2'd1:    mul_a = MUL_A_W'(ir);
                    2'd2:    mul_a = MUL_A_W'(it);
                    default: mul_a = MUL_A_W'(ib);
                endcase
                mul_b = idx_reg[1] ? MUL_B_W'({2'b0, v1}) - MUL_B_W'({2'b0, v0})
                                   : MUL_B_W'({2'b0, u1}) - MUL_B_W'({2'b0, u0});
            end
            ST_ROW_MUL:
            begin
                mul_a = ph_reg;
                mul_b = MUL_B_W'({2'b0, pv1_reg}) - MUL_B_W'({2'b0, pv0_reg});
            end
            ST_COL_MUL:
            begin
                mul_a = pw_reg;
                mul_b = MUL_B_W'({2'b0, pu1_reg}) - MUL_B_W'({2'b0, pu0_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // restoring divider, one quotient bit per cycle; truncates toward zero
    assign div_q = div_neg_reg ? -Q_W'(div_mag_reg) : Q_W'(div_mag_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_run_reg  <= 1'b0;
            div_done_reg <= 1'b0;
        end
        else
        begin
            div_done_reg <= 1'b0;
            if (div_start_reg)
            begin
                div_run_reg <= 1'b1;
                div_neg_reg <= div_num_reg[PROD_W-1];
                div_mag_reg <= div_num_reg[PROD_W-1] ? PROD_W'(-div_num_reg)
                                                     : PROD_W'(div_num_reg);
                div_rem_reg <= '0;
                div_cnt_reg <= '0;
            end
            else if (div_run_reg)
            begin
                if ({div_rem_reg[DEN_W-1:0], div_mag_reg[PROD_W-1]} >= {1'b0, div_den_reg})
                begin
                    div_rem_reg <= {div_rem_reg[DEN_W-1:0], div_mag_reg[PROD_W-1]}
                                   - {1'b0, div_den_reg};
                    div_mag_reg <= {div_mag_reg[PROD_W-2:0], 1'b1};
                end
                else
                begin
                    div_rem_reg <= {div_rem_reg[DEN_W-1:0], div_mag_reg[PROD_W-1]};
                    div_mag_reg <= {div_mag_reg[PROD_W-2:0], 1'b0};
                end
                div_cnt_reg <= div_cnt_reg + CNT_W'(1);
                if (div_cnt_reg == CNT_W'(PROD_W - 1))
                begin
                    div_run_reg  <= 1'b0;
                    div_done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy       = (state_reg != ST_IDLE);
    assign cfg_ready  = !busy;
    assign quad_valid = quad_valid_reg;
    assign quad       = quad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            div_ret_reg    <= ST_IDLE;
            slot_reg       <= '0;
            pend_valid_reg <= 1'b0;
            quad_valid_reg <= 1'b0;
            div_start_reg  <= 1'b0;
            idx_reg        <= '0;
            gi_reg         <= '0;
            gj_reg         <= '0;
        end
        else
        begin
            quad_valid_reg <= 1'b0;
            div_start_reg  <= 1'b0;
            if (cfg_valid && cfg_ready)
                slot_reg <= cfg_data;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        cmd_reg   <= cmd;
                        idx_reg   <= '0;
                        state_reg <= ST_SCL_MUL;
                    end
                end

                ST_SCL_MUL:
                begin
                    if (slot_reg == '0 || sw == '0 || sh == '0)
                        state_reg <= ST_FLUSH;
                    else
                        state_reg <= ST_SCL_WB;
                end

                ST_SCL_WB:
                begin
                    scl_reg[idx_reg] <= SCL_W'((prod_reg + PROD_W'(ROUND_Q4)) >>> 8);
                    idx_reg          <= idx_reg + 3'd1;
                    state_reg        <= (idx_reg == 3'd5) ? ST_DECIDE : ST_SCL_MUL;
                end

                ST_DECIDE:
                begin
                    idx_reg <= '0;
                    if (w <= 0 || h <= 0)
                        state_reg <= ST_FLUSH;
                    else if (!nine || (scl_reg[0] == '0 && scl_reg[1] == '0 &&
                                       scl_reg[2] == '0 && scl_reg[3] == '0))
                    begin
                        // plain sprite: one stretched quad, flips reverse the span
                        pend_reg.quad_x       <= cmd_reg.dest_x;
                        pend_reg.quad_y       <= cmd_reg.dest_y;
                        pend_reg.quad_w       <= cmd_reg.dest_w;
                        pend_reg.quad_h       <= cmd_reg.dest_h;
                        pend_reg.tex_u0       <= flipx ? u1 : u0;
                        pend_reg.tex_v0       <= flipy ? v1 : v0;
                        pend_reg.tex_u1       <= flipx ? u0 : u1;
                        pend_reg.tex_v1       <= flipy ? v0 : v1;
                        pend_reg.texture_slot <= slot_reg;
                        pend_reg.quad_color   <= cmd_reg.tint_color;
                        pend_reg.last_quad    <= 1'b0;
                        pend_valid_reg        <= 1'b1;
                        state_reg             <= ST_FLUSH;
                    end
                    else
                        state_reg <= ST_SHR_CHK;
                end

                ST_SHR_CHK:
                begin
                    if (POS_W'(shr_sum) > shr_ext)
                        state_reg <= ST_SHR_MUL;
                    else
                    begin
                        idx_reg   <= idx_reg + 3'd1;
                        state_reg <= idx_reg[0] ? ST_FLIP : ST_SHR_CHK;
                    end
                end

                ST_SHR_MUL:
                begin
                    div_den_reg <= shr_sum;
                    div_ret_reg <= ST_SHR_WB;
                    state_reg   <= ST_DIV_GO;
                end

                ST_SHR_WB:
                begin
                    // insets too large: shrink in proportion, far one takes the remainder
                    scl_reg[{idx_reg[0], 1'b0}] <= SCL_W'(div_q);
                    scl_reg[{idx_reg[0], 1'b1}] <= SCL_W'(shr_ext - POS_W'(div_q));
                    idx_reg   <= idx_reg + 3'd1;
                    state_reg <= idx_reg[0] ? ST_FLIP : ST_SHR_CHK;
                end

                ST_FLIP:
                begin
                    if (flipx)
                    begin
                        scl_reg[0] <= scl_reg[1];
                        scl_reg[1] <= scl_reg[0];
                    end
                    if (flipy)
                    begin
                        scl_reg[2] <= scl_reg[3];
                        scl_reg[3] <= scl_reg[2];
                    end
                    idx_reg   <= '0;
                    state_reg <= ST_TRK_MUL;
                end

                ST_TRK_MUL:
                begin
                    div_den_reg <= DEN_W'(idx_reg[1] ? sh : sw);
                    div_ret_reg <= ST_TRK_WB;
                    state_reg   <= ST_DIV_GO;
                end

                ST_TRK_WB:
                begin
                    trk_reg[idx_reg[1:0]] <= clamp_u16(trk_sum);
                    idx_reg <= idx_reg + 3'd1;
                    if (idx_reg == 3'd3)
                    begin
                        gi_reg    <= '0;
                        gj_reg    <= '0;
                        state_reg <= ST_PC_START;
                    end
                    else
                        state_reg <= ST_TRK_MUL;
                end

                ST_DIV_GO:
                begin
                    div_num_reg   <= prod_reg;
                    div_start_reg <= 1'b1;
                    state_reg     <= ST_DIV_WAIT;
                end

                ST_DIV_WAIT:
                begin
                    if (div_done_reg)
                        state_reg <= div_ret_reg;
                end

                ST_PC_START:
                begin
                    pcx_reg <= dxa;
                    pcy_reg <= dya;
                    pcw_reg <= dxb - dxa;
                    pch_reg <= dyb - dya;
                    ptx_reg <= (gi_reg == 2'd1) ? scl_reg[4] : '0;
                    pty_reg <= (gj_reg == 2'd1) ? scl_reg[5] : '0;
                    pu0_reg <= flipx ? su[2'd3 - gi_reg] : su[gi_reg];
                    pu1_reg <= flipx ? su[2'd2 - gi_reg] : su[gi_reg + 2'd1];
                    pv0_reg <= flipy ? sv[2'd3 - gj_reg] : sv[gj_reg];
                    pv1_reg <= flipy ? sv[2'd2 - gj_reg] : sv[gj_reg + 2'd1];
                    if (dxb - dxa <= 0 || dyb - dya <= 0)
                        state_reg <= ST_NEXT;
                    else
                        state_reg <= ST_REP_X;
                end

                ST_REP_X:
                begin
                    nx_reg <= REP_W'(1);
                    if (ptx_reg <= SCL_W'(HALF_PIXEL_Q4))
                    begin
                        ptx_reg   <= '0;
                        state_reg <= ST_REP_Y;
                    end
                    else
                    begin
                        div_num_reg   <= PROD_W'(pcw_reg + ptx_s - POS_W'(1));
                        div_den_reg   <= DEN_W'(ptx_reg);
                        div_start_reg <= 1'b1;
                        div_ret_reg   <= ST_REP_XWB;
                        state_reg     <= ST_DIV_WAIT;
                    end
                end

                ST_REP_XWB:
                begin
                    if (div_q < 1 || div_q > Q_W'(TILE_REPEAT_MAX))
                        ptx_reg <= '0;
                    else
                        nx_reg <= REP_W'(div_q);
                    state_reg <= ST_REP_Y;
                end

                ST_REP_Y:
                begin
                    ny_reg <= REP_W'(1);
                    py_reg <= pcy_reg;
                    rj_reg <= '0;
                    if (pty_reg <= SCL_W'(HALF_PIXEL_Q4))
                    begin
                        pty_reg   <= '0;
                        state_reg <= ST_ROW;
                    end
                    else
                    begin
                        div_num_reg   <= PROD_W'(pch_reg + pty_s - POS_W'(1));
                        div_den_reg   <= DEN_W'(pty_reg);
                        div_start_reg <= 1'b1;
                        div_ret_reg   <= ST_REP_YWB;
                        state_reg     <= ST_DIV_WAIT;
                    end
                end

                ST_REP_YWB:
                begin
                    if (div_q < 1 || div_q > Q_W'(TILE_REPEAT_MAX))
                        pty_reg <= '0;
                    else
                        ny_reg <= REP_W'(div_q);
                    state_reg <= ST_ROW;
                end

                ST_ROW:
                begin
                    ph_reg   <= row_ph;
                    px_reg   <= pcx_reg;
                    ci_reg   <= '0;
                    pv1q_reg <= pv1_reg;
                    // full repeat ends exactly on the end UV, only a trimmed one needs a lerp
                    state_reg <= (pty_reg != '0 && row_ph != pty_s) ? ST_ROW_MUL : ST_COL;
                end

                ST_ROW_MUL:
                begin
                    div_den_reg <= DEN_W'(pty_reg);
                    div_ret_reg <= ST_ROW_WB;
                    state_reg   <= ST_DIV_GO;
                end

                ST_ROW_WB:
                begin
                    pv1q_reg  <= clamp_u16(lerp_v);
                    state_reg <= ST_COL;
                end

                ST_COL:
                begin
                    pw_reg    <= col_pw;
                    pu1q_reg  <= pu1_reg;
                    state_reg <= (ptx_reg != '0 && col_pw != ptx_s) ? ST_COL_MUL : ST_EMIT;
                end

                ST_COL_MUL:
                begin
                    div_den_reg <= DEN_W'(ptx_reg);
                    div_ret_reg <= ST_COL_WB;
                    state_reg   <= ST_DIV_GO;
                end

                ST_COL_WB:
                begin
                    pu1q_reg  <= clamp_u16(lerp_u);
                    state_reg <= ST_EMIT;
                end

                ST_EMIT:
                begin
                    // one-deep hold so the final quad can be flagged
                    if (pend_valid_reg)
                    begin
                        quad_reg       <= pend_reg;
                        quad_valid_reg <= 1'b1;
                    end
                    pend_valid_reg        <= 1'b1;
                    pend_reg.quad_x       <= sat_s16(px_reg);
                    pend_reg.quad_y       <= sat_s16(py_reg);
                    pend_reg.quad_w       <= sat_s16(pw_reg);
                    pend_reg.quad_h       <= sat_s16(ph_reg);
                    pend_reg.tex_u0       <= pu0_reg;
                    pend_reg.tex_v0       <= pv0_reg;
                    pend_reg.tex_u1       <= pu1q_reg;
                    pend_reg.tex_v1       <= pv1q_reg;
                    pend_reg.texture_slot <= slot_reg;
                    pend_reg.quad_color   <= cmd_reg.tint_color;
                    pend_reg.last_quad    <= 1'b0;
                    px_reg <= px_reg + ptx_s;
                    ci_reg <= ci_reg + REP_W'(1);
                    if (ci_reg + REP_W'(1) == nx_reg)
                    begin
                        py_reg <= py_reg + pty_s;
                        rj_reg <= rj_reg + REP_W'(1);
                        state_reg <= (rj_reg + REP_W'(1) == ny_reg) ? ST_NEXT : ST_ROW;
                    end
                    else
                        state_reg <= ST_COL;
                end

                ST_NEXT:
                begin
                    if (gi_reg == 2'd2)
                    begin
                        gi_reg    <= '0;
                        gj_reg    <= gj_reg + 2'd1;
                        state_reg <= (gj_reg == 2'd2) ? ST_FLUSH : ST_PC_START;
                    end
                    else
                    begin
                        gi_reg    <= gi_reg + 2'd1;
                        state_reg <= ST_PC_START;
                    end
                end

                ST_FLUSH:
                begin
                    if (pend_valid_reg)
                    begin
                        quad_reg           <= pend_reg;
                        quad_reg.last_quad <= 1'b1;
                        quad_valid_reg     <= 1'b1;
                        pend_valid_reg     <= 1'b0;
                    end
                    state_reg <= ST_IDLE;
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: test/nine_slice_sprite_expander_unit_tb.sv
// Testbench for the nine-slice sprite expander: directed and random commands, self-checked.
`timescale 1ns / 100ps
module nine_slice_sprite_expander_unit_tb;
    import nsse_pkg::*;

    localparam longint CYCLE_LIMIT = 3000000;
    localparam int     MAX_REPORTS = 10;

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   start = 1'b0;
    logic   busy;
    cmd_t   cmd = '0;
    logic   cfg_valid = 1'b0;
    logic   cfg_ready;
    logic [15:0] cfg_data = '0;
    logic   quad_valid;
    quad_t  quad;

    nine_slice_sprite_expander_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .quad_valid (quad_valid),
        .quad       (quad)
    );

    always #5 clk = ~clk;

    // Expected quads in emission order, and our copy of the atlas slot register.
    quad_t       quad_q[$];
    logic [15:0] slot_shadow = '0;
    int          mismatches = 0;
    int          gap_pct = 0;        // chance (percent) of an idle stretch after a command
    longint      cycles = 0;

    // Handshake inputs are sampled mid-cycle, so the value seen is the one the DUT
    // holds at the next rising edge regardless of event ordering.
    logic busy_seen = 1'b1;
    logic ready_seen = 1'b0;
    always @(negedge clk)
    begin
        busy_seen  <= busy;
        ready_seen <= cfg_ready;
    end

    // ---------------------------------------------------------------- predictor
    function automatic longint scale_q4(longint n, longint s);
        if (n <= 0)
            return 0;
        return (n * s + 128) >>> 8;
    endfunction

    function automatic longint uv_interp(longint a, longint b, longint num, longint den);
        if (den == 0)
            return b;
        return a + (b - a) * num / den;
    endfunction

    function automatic logic [15:0] sat16(longint v);
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[15:0];
    endfunction

    function automatic longint clamp_uv(longint v);
        if (v < 0)
            return 0;
        if (v > 65535)
            return 65535;
        return v;
    endfunction

    function automatic longint repeat_count(longint len, inout longint pitch);
        longint cnt;
        if (pitch <= HALF_PIXEL_Q4)
        begin
            pitch = 0;
            return 1;
        end
        cnt = (len + pitch - 1) / pitch;
        if (cnt < 1 || cnt > TILE_REPEAT_MAX)
        begin
            pitch = 0;
            return 1;
        end
        return cnt;
    endfunction

    task automatic push_quad(longint x, longint y, longint w, longint h, longint u0,
                             longint v0, longint u1, longint v1, logic [31:0] color);
        quad_t q;
        q.quad_x       = sat16(x);
        q.quad_y       = sat16(y);
        q.quad_w       = sat16(w);
        q.quad_h       = sat16(h);
        q.tex_u0       = 16'(clamp_uv(u0));
        q.tex_v0       = 16'(clamp_uv(v0));
        q.tex_u1       = 16'(clamp_uv(u1));
        q.tex_v1       = 16'(clamp_uv(v1));
        q.texture_slot = slot_shadow;
        q.quad_color   = color;
        q.last_quad    = 1'b0;
        quad_q.push_back(q);
    endtask

    // One grid piece; tiles when a pitch is given, trimming the far repeat in UV.
    task automatic piece_quads(longint x, longint y, longint w, longint h, longint u0,
                               longint v0, longint u1, longint v1, longint ptx,
                               longint pty, logic [31:0] color);
        longint nx, ny, py, ph, pv1, px, pw, pu1;
        if (w <= 0 || h <= 0)
            return;
        nx = repeat_count(w, ptx);
        ny = repeat_count(h, pty);
        for (longint j = 0; j < ny; j++)
        begin
            py = (pty != 0) ? y + j * pty : y;
            ph = (pty != 0) ? pty : h;
            if (py + ph > y + h)
                ph = y + h - py;
            pv1 = (pty != 0) ? uv_interp(v0, v1, ph, pty) : v1;
            for (longint i = 0; i < nx; i++)
            begin
                px = (ptx != 0) ? x + i * ptx : x;
                pw = (ptx != 0) ? ptx : w;
                if (px + pw > x + w)
                    pw = x + w - px;
                pu1 = (ptx != 0) ? uv_interp(u0, u1, pw, ptx) : u1;
                push_quad(px, py, pw, ph, u0, v0, pu1, pv1, color);
            end
        end
    endtask

    task automatic predict_quads(cmd_t c);
        longint x, y, w, h, s, u0, v0, u1, v1, sw, sh, il, ir, it, ib;
        longint lft, rgt, top, bot, k, tmp, ptx, pty;
        longint dx[4], dy[4], su[4], sv[4];
        logic   flipx, flipy, tile, nine;
        int     before_n, si, sj;
        before_n = quad_q.size();
        x = longint'(c.dest_x);  y = longint'(c.dest_y);
        w = longint'(c.dest_w);  h = longint'(c.dest_h);
        s = c.inset_scale;
        u0 = c.uv_rect[15:0];  v0 = c.uv_rect[31:16];
        u1 = c.uv_rect[47:32]; v1 = c.uv_rect[63:48];
        sw = c.source_size[15:0]; sh = c.source_size[31:16];
        il = c.slice_insets[15:0];  ir = c.slice_insets[31:16];
        it = c.slice_insets[47:32]; ib = c.slice_insets[63:48];
        flipx = c.mode_flags[0]; flipy = c.mode_flags[1];
        tile  = c.mode_flags[2]; nine  = c.mode_flags[3];

        if (slot_shadow == 0 || sw == 0 || sh == 0)
            return;
        lft = scale_q4(il, s); rgt = scale_q4(ir, s);
        top = scale_q4(it, s); bot = scale_q4(ib, s);

        // plain sprite, or nine-slice with nothing left of its insets: one quad
        if (!nine || (lft == 0 && rgt == 0 && top == 0 && bot == 0))
        begin
            if (w <= 0 || h <= 0)
                return;
            push_quad(x, y, w, h, flipx ? u1 : u0, flipy ? v1 : v0,
                      flipx ? u0 : u1, flipy ? v0 : v1, c.tint_color);
            quad_q[quad_q.size()-1].last_quad = 1'b1;
            return;
        end
        if (w <= 0 || h <= 0)
            return;

        // shrink insets that do not fit, then swap them under a flip
        if (lft + rgt > w)
        begin
            k = lft * w / (lft + rgt); rgt = w - k; lft = k;
        end
        if (top + bot > h)
        begin
            k = top * h / (top + bot); bot = h - k; top = k;
        end
        if (flipx)
        begin
            tmp = lft; lft = rgt; rgt = tmp;
        end
        if (flipy)
        begin
            tmp = top; top = bot; bot = tmp;
        end

        dx[0] = x; dx[1] = x + lft; dx[2] = x + w - rgt; dx[3] = x + w;
        dy[0] = y; dy[1] = y + top; dy[2] = y + h - bot; dy[3] = y + h;
        su[0] = u0; su[3] = u1;
        su[1] = clamp_uv(u0 + il * (u1 - u0) / sw);
        su[2] = clamp_uv(u1 - ir * (u1 - u0) / sw);
        sv[0] = v0; sv[3] = v1;
        sv[1] = clamp_uv(v0 + it * (v1 - v0) / sh);
        sv[2] = clamp_uv(v1 - ib * (v1 - v0) / sh);

        ptx = (tile && sw - il - ir > 0) ? scale_q4(sw - il - ir, s) : 0;
        pty = (tile && sh - it - ib > 0) ? scale_q4(sh - it - ib, s) : 0;

        for (int j = 0; j < 3; j++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                si = flipx ? 3 - i : i;
                sj = flipy ? 3 - j : j;
                piece_quads(dx[i], dy[j], dx[i+1] - dx[i], dy[j+1] - dy[j],
                            su[si], sv[sj], flipx ? su[si-1] : su[si+1],
                            flipy ? sv[sj-1] : sv[sj+1],
                            (i == 1) ? ptx : 0, (j == 1) ? pty : 0, c.tint_color);
            end
        end
        if (quad_q.size() > before_n)
            quad_q[quad_q.size()-1].last_quad = 1'b1;
    endtask

    // ---------------------------------------------------------------- checker
    // Each strobed quad is compared against the oldest expectation.
    always @(negedge clk)
    begin
        if (rst_n && quad_valid)
        begin
            if (quad_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected quad %p", quad);
            end
            else
            begin
                quad_t want;
                want = quad_q.pop_front();
                if (quad !== want)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("quad mismatch\n  expected %p\n  actual   %p", want, quad);
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("nine_slice_sprite_expander_unit_tb: FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------- drivers
    // One command word: held until taken, then start drops before the next command.
    task automatic send_cmd(cmd_t c);
        @(posedge clk);
        start <= 1'b1;
        cmd   <= c;
        do
            @(posedge clk);
        while (busy_seen);
        start <= 1'b0;
        predict_quads(c);
        if ($urandom_range(99) < gap_pct)
            repeat ($urandom_range(1, 12)) @(posedge clk);
    endtask

    // Wait for every expected quad, then give the sequencer time to go idle.
    task automatic drain;
        do
            @(posedge clk);
        while (quad_q.size() != 0 || busy_seen);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_slot(logic [15:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!ready_seen);
        cfg_valid   <= 1'b0;
        slot_shadow  = v;
    endtask

    function automatic cmd_t make_cmd(int x, int y, int w, int h, int s, int sw, int sh,
                                      int l, int r, int t, int b, logic [3:0] fl);
        cmd_t c;
        c.dest_x       = 16'(x);
        c.dest_y       = 16'(y);
        c.dest_w       = 16'(w);
        c.dest_h       = 16'(h);
        c.inset_scale  = 16'(s);
        c.uv_rect      = {$urandom, $urandom};
        c.source_size  = {16'(sh), 16'(sw)};
        c.slice_insets = {16'(b), 16'(t), 16'(r), 16'(l)};
        c.mode_flags   = fl;
        c.tint_color   = $urandom;
        return c;
    endfunction

    // Mostly well-formed sprites, most of them nine-slice, whose tiling may exceed the repeat cap;
    // the rest is raw noise across every field bit.
    function automatic cmd_t random_cmd();
        cmd_t c;
        int   sw, sh, s;
        if ($urandom_range(99) < 20)
        begin
            c = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom};
            return c;
        end
        sw = $urandom_range(1, 64);
        sh = $urandom_range(1, 64);
        s  = ($urandom_range(1)) ? 16'h1000 : $urandom_range(16'h0200, 16'h4000);
        c = make_cmd($urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768,
                     $urandom_range(1, 4000) - 40, $urandom_range(1, 4000) - 40, s, sw, sh,
                     $urandom_range(0, sw / 2), $urandom_range(0, sw / 2),
                     $urandom_range(0, sh / 2), $urandom_range(0, sh / 2),
                     {($urandom_range(99) < 85), 3'($urandom)});
        if ($urandom_range(9) == 0)
            c.slice_insets = {$urandom, $urandom};
        return c;
    endfunction

    // ---------------------------------------------------------------- tests
    task automatic test_no_atlas;
        // slot zero after reset: nothing may come out
        send_cmd(make_cmd(0, 0, 320, 320, 16'h1000, 16, 16, 4, 4, 4, 4, 4'b1000));
        send_cmd(make_cmd(0, 0, 320, 320, 16'h1000, 16, 16, 0, 0, 0, 0, 4'b0000));
        write_slot(16'hffff);
    endtask

    task automatic test_plain;
        send_cmd(make_cmd(16, 32, 160, 96, 16'h1000, 8, 8, 2, 2, 2, 2, 4'b0000));
        send_cmd(make_cmd(0, 0, 160, 96, 16'h1000, 8, 8, 2, 2, 2, 2, 4'b0011));
        send_cmd(make_cmd(0, 0, 160, 96, 16'h0000, 8, 8, 2, 2, 2, 2, 4'b1001));  // insets vanish
        send_cmd(make_cmd(-32768, -32768, 32767, 32767, 16'hffff, 65535, 65535,
                          0, 0, 0, 0, 4'b1110));
        send_cmd(make_cmd(32767, 32767, 32767, 32767, 16'h1000, 1, 1, 0, 0, 0, 0, 4'b0000));
        send_cmd(make_cmd(0, 0, 0, 96, 16'h1000, 8, 8, 0, 0, 0, 0, 4'b0000));     // zero width
        send_cmd(make_cmd(0, 0, 96, -32768, 16'h1000, 8, 8, 0, 0, 0, 0, 4'b0000)); // negative
        send_cmd(make_cmd(0, 0, 96, 96, 16'h1000, 0, 8, 1, 1, 1, 1, 4'b1000));    // sw zero
        send_cmd(make_cmd(0, 0, 96, 96, 16'h1000, 8, 0, 1, 1, 1, 1, 4'b1000));    // sh zero
    endtask

    task automatic test_nine_slice;
        write_slot(16'h0001);
        send_cmd(make_cmd(100, 200, 640, 480, 16'h1000, 32, 32, 8, 8, 8, 8, 4'b1000));
        send_cmd(make_cmd(100, 200, 640, 480, 16'h1000, 32, 32, 4, 10, 6, 2, 4'b1011));
        send_cmd(make_cmd(0, 0, 200, 100, 16'h1000, 32, 32, 30, 10, 20, 20, 4'b1000)); // shrink
        send_cmd(make_cmd(0, 0, 300, 300, 16'hffff, 65535, 65535, 65535, 65535, 65535,
                          65535, 4'b1111));
        send_cmd(make_cmd(0, 0, -16, 480, 16'h1000, 32, 32, 8, 8, 8, 8, 4'b1000));
        send_cmd(make_cmd(32000, -32000, 32767, 32767, 16'h4000, 40, 40, 9, 9, 9, 9,
                          4'b1000));
    endtask

    task automatic test_tiling;
        // pitch 16 px: 3 repeats with a trimmed tail on x, exactly 2 on y
        send_cmd(make_cmd(0, 0, 16*16 + 16*36, 16*16 + 16*32, 16'h1000, 32, 32, 8, 8, 8, 8,
                          4'b1100));
        send_cmd(make_cmd(0, 0, 16*16 + 16*36, 16*16 + 16*32, 16'h1000, 32, 32, 8, 8, 8, 8,
                          4'b1111));
        // repeat cap exceeded: stretch
        send_cmd(make_cmd(0, 0, 16*200, 16*200, 16'h1000, 32, 32, 8, 8, 8, 8, 4'b1100));
        // pitch of half a pixel or less, and a negative centre span
        send_cmd(make_cmd(0, 0, 160, 160, 16'h0080, 32, 32, 8, 8, 8, 8, 4'b1100));
        send_cmd(make_cmd(0, 0, 160, 160, 16'h1000, 8, 8, 6, 6, 6, 6, 4'b1100));
        // the deepest grid: 4x4 centre repeats
        send_cmd(make_cmd(0, 0, 16*16 + 16*60, 16*16 + 16*60, 16'h1000, 32, 32, 8, 8, 8, 8,
                          4'b1100));
        // hold off until the block has emptied out
        drain();
    endtask

    task automatic test_random;
        logic [15:0] slots[4];
        int          pct[4];
        slots = '{16'h0000, 16'h8001, 16'($urandom_range(1, 65535)), 16'h0001};
        pct   = '{0, 70, 24, 70};
        for (int ph = 0; ph < 4; ph++)
        begin
            write_slot(slots[ph]);
            gap_pct = pct[ph];
            repeat ((ph == 0) ? 12 : 50) send_cmd(random_cmd());
        end
    endtask

    // ---------------------------------------------------------------- sequence
    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_no_atlas();
        test_plain();
        test_nine_slice();
        test_tiling();
        test_random();
        drain();
        if (mismatches == 0 && quad_q.size() == 0)
            $display("nine_slice_sprite_expander_unit_tb: PASS");
        else
            $display("nine_slice_sprite_expander_unit_tb: FAIL");
        $finish;
    end

endmodule
